// ===== design/tlpt_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpt_pkg: shared types and constants of the two-level page table engine
// Field widths, action and status codes, and the sequencer state encoding.
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int VPAGE_W = 12;
	localparam int FRAME_W = 20;
	localparam int FLAGS_W = 12;
	localparam int ENTRY_W = 32;
	localparam int POS_W   = 4;

	// Protect bit position after reset
	localparam logic [POS_W-1:0] PROTECT_POS_RST = 4'd9;
	// Highest flag bit that can act as protect bit
	localparam logic [POS_W-1:0] PROTECT_POS_MAX = 4'd11;

	typedef enum logic [2:0] {
		ACT_MAP       = 3'd0,
		ACT_UNMAP     = 3'd1,
		ACT_TRANSLATE = 3'd2,
		ACT_PROTECT   = 3'd3,
		ACT_UNPROTECT = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MAPPED    = 2'd1,
		ST_ABSENT    = 2'd2,
		ST_PROTECTED = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DIV_ENT,
		S_DIV_SLOT,
		S_ADDR,
		S_LOOK,
		S_READ,
		S_CHECK,
		S_CLEAR,
		S_MAPW,
		S_DONE
	} state_t;

endpackage

// ===== design/tlpt_divider.sv =====
// ----------------------------------------------------------------------------
// tlpt_divider: shared divide-by-constant unit
// Quotient by reciprocal multiplication, then remainder by multiply-back.
// Exact for any dividend below 2**DEND_W when recip is
// ceil(2**(DEND_W+DSOR_W) / divisor) and 2 <= divisor < 2**DSOR_W.
// start is registered into busy, then into a one-cycle done pulse.
// ----------------------------------------------------------------------------
module tlpt_divider #(
	parameter int DEND_W = 12,
	parameter int DSOR_W = 9
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [DEND_W-1:0]        dividend,
	input  logic [DSOR_W-1:0]        divisor,
	input  logic [DEND_W+DSOR_W-1:0] recip,
	output logic                     done,
	output logic [DEND_W-1:0]        quotient,
	output logic [DSOR_W-1:0]        remainder
);

	localparam int SHIFT_W = DEND_W + DSOR_W;
	localparam int PROD_W  = DEND_W + SHIFT_W;

	logic              busy_q;
	logic              done_q;
	logic [DEND_W-1:0] dend_q;
	logic [DSOR_W-1:0] dsor_q;
	logic [DEND_W-1:0] quo_q;
	logic [DSOR_W-1:0] rem_q;

	logic [PROD_W-1:0]  prod;
	logic [SHIFT_W-1:0] back;

	always_comb begin
		prod = PROD_W'(dividend) * PROD_W'(recip);
		// remainder is below the divisor, so the upper bits drop out
		back = SHIFT_W'(dend_q) - SHIFT_W'(quo_q) * SHIFT_W'(dsor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dend_q <= dividend;
			dsor_q <= divisor;
			quo_q  <= prod[PROD_W-1:SHIFT_W];
		end
		if (busy_q) begin
			rem_q <= back[DSOR_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== design/tlpt_ram.sv =====
// ----------------------------------------------------------------------------
// tlpt_ram: simple dual-port memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tlpt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/two_level_page_table_engine_top.sv =====
// ----------------------------------------------------------------------------
// two_level_page_table_engine_top: two-level page table engine
// Directory of present bits plus one table of 32-bit entries per slot;
// handles map, unmap, translate, protect and unprotect transactions.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Handshake            | Payload
//  ----------+-----------+----------------------+---------------------------------------
//  request   | in        | req_valid/req_stall  | action, virt_page, phys_frame,
//            |           |                      | entry_flags
//  response  | out       | rsp_valid/rsp_stall  | status, frame_out
//  config    | in        | cfg_wr_en            | cfg_wr_data (protect bit position)
//
//  A request steps through two passes of the shared divide unit (entry
//  index, then slot), address, directory look, table read, check and done.
//  The next request is taken once the sequencer is back in idle.
//  An absent slot on unmap, translate, protect or unprotect, or an unknown
//  action, skips the table read and answers from the directory look.
//  A map to an absent slot first clears the slot table, one entry per cycle
//  through the single table write port.
//  After reset the directory is swept clear slot by slot; requests stall.
//  One transaction is in flight; the response register holds while rsp_stall
//  is high, and the next request may be taken meanwhile.
//
module two_level_page_table_engine_top #(
	parameter int DIR_SLOTS     = 16,
	parameter int TABLE_ENTRIES = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [2:0]                     action,
	input  logic [tlpt_pkg::VPAGE_W-1:0]   virt_page,
	input  logic [tlpt_pkg::FRAME_W-1:0]   phys_frame,
	input  logic [tlpt_pkg::FLAGS_W-1:0]   entry_flags,
	// response channel
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [1:0]                     status,
	output logic [tlpt_pkg::FRAME_W-1:0]   frame_out,
	// configuration
	input  logic                           cfg_wr_en,
	input  logic [tlpt_pkg::POS_W-1:0]     cfg_wr_data
);

	localparam int SLOT_W  = $clog2(DIR_SLOTS);
	localparam int ENT_W   = $clog2(TABLE_ENTRIES);
	localparam int ADDR_W  = $clog2(DIR_SLOTS * TABLE_ENTRIES);
	localparam int DIV_MAX = (DIR_SLOTS > TABLE_ENTRIES) ? DIR_SLOTS : TABLE_ENTRIES;
	localparam int DSOR_W  = $clog2(DIV_MAX + 1);
	localparam int FLAGS_W = tlpt_pkg::FLAGS_W;
	localparam int FRAME_W = tlpt_pkg::FRAME_W;
	localparam int ENTRY_W = tlpt_pkg::ENTRY_W;
	localparam int DIV_SHIFT = tlpt_pkg::VPAGE_W + DSOR_W;

	localparam logic [DSOR_W-1:0] TE_DIV   = DSOR_W'(TABLE_ENTRIES);
	localparam logic [DSOR_W-1:0] DS_DIV   = DSOR_W'(DIR_SLOTS);
	// Rounded-up reciprocals for the shared divide unit
	localparam logic [DIV_SHIFT-1:0] TE_RECIP = DIV_SHIFT'(
		((longint'(1) << DIV_SHIFT) + longint'(TABLE_ENTRIES) - 1) / longint'(TABLE_ENTRIES));
	localparam logic [DIV_SHIFT-1:0] DS_RECIP = DIV_SHIFT'(
		((longint'(1) << DIV_SHIFT) + longint'(DIR_SLOTS) - 1) / longint'(DIR_SLOTS));
	localparam logic [ADDR_W-1:0] TE_ADDR  = ADDR_W'(TABLE_ENTRIES);
	localparam logic [ENT_W-1:0]  ENT_LAST = ENT_W'(TABLE_ENTRIES - 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(DIR_SLOTS - 1);

	// One-hot protect mask over the flag bits; empty above bit eleven
	function automatic logic [FLAGS_W-1:0] protect_mask(input logic [tlpt_pkg::POS_W-1:0] pos);
		logic [FLAGS_W-1:0] m;
		m = '0;
		if (pos <= tlpt_pkg::PROTECT_POS_MAX) begin
			m = FLAGS_W'(1) << pos;
		end
		return m;
	endfunction

	// ------------------------------------------------------------------
	// State and registers
	// ------------------------------------------------------------------
	tlpt_pkg::state_t  state_q, state_d;

	logic [tlpt_pkg::POS_W-1:0] protect_pos_q;

	tlpt_pkg::action_t act_q;
	logic [FRAME_W-1:0] phys_q;
	logic [FLAGS_W-1:0] flags_q;
	logic [ENT_W-1:0]   entry_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [ADDR_W-1:0]  base_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [ENT_W-1:0]   clr_q;
	logic [SLOT_W-1:0]  init_q;

	tlpt_pkg::status_t  res_status_q, res_status_d;
	logic [FRAME_W-1:0] res_frame_q, res_frame_d;
	logic               res_load;

	logic               rsp_valid_q;
	logic [1:0]         status_q;
	logic [FRAME_W-1:0] frame_out_q;

	logic               req_accept;
	logic               out_free;
	logic [FLAGS_W-1:0] pmask;

	// divider
	logic                      div_start;
	logic [tlpt_pkg::VPAGE_W-1:0] div_dividend;
	logic [DSOR_W-1:0]         div_divisor;
	logic [DIV_SHIFT-1:0]      div_recip;
	logic                      div_done;
	logic [tlpt_pkg::VPAGE_W-1:0] div_quo;
	logic [DSOR_W-1:0]         div_rem;

	// directory memory
	logic              dir_we;
	logic [SLOT_W-1:0] dir_waddr;
	logic              dir_wdata;
	logic              dir_rdata;

	// entry memory
	logic               ent_we;
	logic [ADDR_W-1:0]  ent_waddr;
	logic [ENTRY_W-1:0] ent_wdata;
	logic [ENTRY_W-1:0] ent_rdata;

	assign req_accept = req_valid && !req_stall;
	assign out_free   = !rsp_valid_q || !rsp_stall;
	assign pmask      = protect_mask(protect_pos_q);

	// ------------------------------------------------------------------
	// Shared divider: virt_page / TABLE_ENTRIES, then quotient / DIR_SLOTS
	// ------------------------------------------------------------------
	assign div_dividend = (state_q == tlpt_pkg::S_IDLE) ? virt_page : div_quo;
	assign div_divisor  = (state_q == tlpt_pkg::S_IDLE) ? TE_DIV : DS_DIV;
	assign div_recip    = (state_q == tlpt_pkg::S_IDLE) ? TE_RECIP : DS_RECIP;

	tlpt_divider #(
		.DEND_W (tlpt_pkg::VPAGE_W),
		.DSOR_W (DSOR_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.recip     (div_recip),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Directory present bits, swept to zero after reset
	tlpt_ram #(
		.WIDTH (1),
		.DEPTH (DIR_SLOTS)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.raddr (slot_q),
		.rdata (dir_rdata)
	);

	// Page table entries, DIR_SLOTS tables of TABLE_ENTRIES each
	tlpt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DIR_SLOTS * TABLE_ENTRIES)
	) u_ent_ram (
		.clk   (clk),
		.we    (ent_we),
		.waddr (ent_waddr),
		.wdata (ent_wdata),
		.raddr (addr_q),
		.rdata (ent_rdata)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlpt_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_stall    = 1'b1;
		div_start    = 1'b0;
		dir_we       = 1'b0;
		dir_waddr    = slot_q;
		dir_wdata    = 1'b0;
		ent_we       = 1'b0;
		ent_waddr    = addr_q;
		ent_wdata    = '0;
		res_load     = 1'b0;
		res_status_d = tlpt_pkg::ST_OK;
		res_frame_d  = '0;

		unique case (state_q)
			tlpt_pkg::S_INIT: begin
				// clear one directory slot per cycle
				dir_we    = 1'b1;
				dir_waddr = init_q;
				if (init_q == SLOT_LAST) begin
					state_d = tlpt_pkg::S_IDLE;
				end
			end
			tlpt_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					div_start = 1'b1;
					state_d   = tlpt_pkg::S_DIV_ENT;
				end
			end
			tlpt_pkg::S_DIV_ENT: begin
				if (div_done) begin
					// reuse the divider for the slot number
					div_start = 1'b1;
					state_d   = tlpt_pkg::S_DIV_SLOT;
				end
			end
			tlpt_pkg::S_DIV_SLOT: begin
				if (div_done) begin
					state_d = tlpt_pkg::S_ADDR;
				end
			end
			tlpt_pkg::S_ADDR: begin
				state_d = tlpt_pkg::S_LOOK;
			end
			tlpt_pkg::S_LOOK: begin
				case (act_q) inside
					tlpt_pkg::ACT_MAP: begin
						if (!dir_rdata) begin
							// create the slot, then clear its table
							dir_we    = 1'b1;
							dir_wdata = 1'b1;
							state_d   = tlpt_pkg::S_CLEAR;
						end else begin
							state_d = tlpt_pkg::S_READ;
						end
					end
					tlpt_pkg::ACT_UNMAP, tlpt_pkg::ACT_TRANSLATE,
					tlpt_pkg::ACT_PROTECT, tlpt_pkg::ACT_UNPROTECT: begin
						if (!dir_rdata) begin
							res_load     = 1'b1;
							res_status_d = tlpt_pkg::ST_ABSENT;
							state_d      = tlpt_pkg::S_DONE;
						end else begin
							state_d = tlpt_pkg::S_READ;
						end
					end
					default: begin
						// unknown action: no change, plain done
						res_load = 1'b1;
						state_d  = tlpt_pkg::S_DONE;
					end
				endcase
			end
			tlpt_pkg::S_READ: begin
				state_d = tlpt_pkg::S_CHECK;
			end
			tlpt_pkg::S_CHECK: begin
				res_load = 1'b1;
				state_d  = tlpt_pkg::S_DONE;
				if (act_q == tlpt_pkg::ACT_MAP) begin
					if (ent_rdata[0]) begin
						res_status_d = tlpt_pkg::ST_MAPPED;
					end else begin
						ent_we    = 1'b1;
						ent_wdata = {phys_q, flags_q};
					end
				end else if (!ent_rdata[0]) begin
					res_status_d = tlpt_pkg::ST_ABSENT;
				end else begin
					case (act_q)
						tlpt_pkg::ACT_UNMAP: begin
							if (|(ent_rdata[FLAGS_W-1:0] & pmask)) begin
								res_status_d = tlpt_pkg::ST_PROTECTED;
							end else begin
								res_frame_d = ent_rdata[ENTRY_W-1:FLAGS_W];
								ent_we      = 1'b1;
							end
						end
						tlpt_pkg::ACT_TRANSLATE: begin
							res_frame_d = ent_rdata[ENTRY_W-1:FLAGS_W];
						end
						tlpt_pkg::ACT_PROTECT: begin
							ent_we    = 1'b1;
							ent_wdata = ent_rdata | {{(ENTRY_W - FLAGS_W){1'b0}}, pmask};
						end
						tlpt_pkg::ACT_UNPROTECT: begin
							ent_we    = 1'b1;
							ent_wdata = ent_rdata & ~{{(ENTRY_W - FLAGS_W){1'b0}}, pmask};
						end
						default: begin
						end
					endcase
				end
			end
			tlpt_pkg::S_CLEAR: begin
				ent_we    = 1'b1;
				ent_waddr = base_q + ADDR_W'(clr_q);
				if (clr_q == ENT_LAST) begin
					state_d = tlpt_pkg::S_MAPW;
				end
			end
			tlpt_pkg::S_MAPW: begin
				// freshly cleared entry is never present
				ent_we    = 1'b1;
				ent_wdata = {phys_q, flags_q};
				res_load  = 1'b1;
				state_d   = tlpt_pkg::S_DONE;
			end
			tlpt_pkg::S_DONE: begin
				if (out_free) begin
					state_d = tlpt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = tlpt_pkg::S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control counters and configuration
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q        <= '0;
			protect_pos_q <= tlpt_pkg::PROTECT_POS_RST;
		end else begin
			if (state_q == tlpt_pkg::S_INIT) begin
				init_q <= init_q + 1'b1;
			end
			if (cfg_wr_en) begin
				protect_pos_q <= cfg_wr_data;
			end
		end
	end

	// ------------------------------------------------------------------
	// Transaction datapath
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_accept) begin
			act_q   <= tlpt_pkg::action_t'(action);
			phys_q  <= phys_frame;
			flags_q <= entry_flags;
		end
		if (state_q == tlpt_pkg::S_DIV_ENT && div_done) begin
			entry_q <= div_rem[ENT_W-1:0];
		end
		if (state_q == tlpt_pkg::S_DIV_SLOT && div_done) begin
			slot_q <= div_rem[SLOT_W-1:0];
		end
		if (state_q == tlpt_pkg::S_ADDR) begin
			base_q <= ADDR_W'(slot_q) * TE_ADDR;
		end
		if (state_q == tlpt_pkg::S_LOOK) begin
			addr_q <= base_q + ADDR_W'(entry_q);
			clr_q  <= '0;
		end
		if (state_q == tlpt_pkg::S_CLEAR) begin
			clr_q <= clr_q + 1'b1;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_frame_q  <= res_frame_d;
		end
	end

	// ------------------------------------------------------------------
	// Response register: hold while stalled, load from the finished result
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == tlpt_pkg::S_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == tlpt_pkg::S_DONE && out_free) begin
			status_q    <= res_status_q;
			frame_out_q <= res_frame_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign frame_out = frame_out_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_accept_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		req_accept |=> (state_q == tlpt_pkg::S_DIV_ENT))
		else $error("accepted request did not start the divider");

	a_ent_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ent_we |-> (state_q == tlpt_pkg::S_CHECK || state_q == tlpt_pkg::S_CLEAR ||
			state_q == tlpt_pkg::S_MAPW))
		else $error("table write outside a write state");

	a_slot_create_absent: assert property (@(posedge clk) disable iff (!arst_n)
		(dir_we && state_q == tlpt_pkg::S_LOOK) |-> (!dir_rdata && act_q == tlpt_pkg::ACT_MAP))
		else $error("slot created while already present");

	a_done_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tlpt_pkg::S_DONE && out_free) |=>
			(rsp_valid_q && state_q == tlpt_pkg::S_IDLE))
		else $error("finished result not moved to the response register");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(div_done) |-> (state_q == tlpt_pkg::S_DIV_ENT ||
			state_q == tlpt_pkg::S_DIV_SLOT))
		else $error("divider finished outside a divide state");

endmodule
